### src/ffpa_pkg.sv
// Shared types and constants of the first-fit pool allocator.
package ffpa_pkg;

    // Field widths of the request and response transactions
    localparam int OFFS_W = 20;
    localparam int STAT_W = 2;

    // Size rounding and split margin
    localparam int ALIGN_MASK  = 15;
    localparam int SPLIT_SLACK = 8;

    // Request kinds
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Response status codes
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOFIT   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BADFREE = 2'd2;

    typedef logic [OFFS_W-1:0] t_offset;
    typedef logic [STAT_W-1:0] t_status;

    // One chunk table entry
    typedef struct packed {
        t_offset start;
        t_offset size;
        logic    free;
    } t_chunk;

endpackage

### src/ffpa_req_if.sv
// Request channel: allocate or free transactions.
interface ffpa_req_if;
    import ffpa_pkg::*;

    logic    valid;
    logic    ready;
    logic    req_type;
    t_offset req_size;
    t_offset free_offset;

    modport source (output valid, req_type, req_size, free_offset, input ready);
    modport sink   (input valid, req_type, req_size, free_offset, output ready);
endinterface

### src/ffpa_rsp_if.sv
// Response channel: granted offset and status.
interface ffpa_rsp_if;
    import ffpa_pkg::*;

    logic    valid;
    logic    ready;
    t_offset payload_offset;
    t_status status;

    modport source (output valid, payload_offset, status, input ready);
    modport sink   (input valid, payload_offset, status, output ready);
endinterface

### src/first_fit_pool_allocator_top.sv
// Top level of the first-fit pool allocator.
//
// The pool is tracked as an address-ordered chunk table held in one RAM
// (start, payload size, free mark per entry). After reset the block writes
// the initial whole-pool chunk into entry 0, then raises ready. Requests
// are handled one at a time and each produces exactly one response
// transaction; a finished response waits in an output register while the
// next request is already taken. An allocate scans the table for the first
// free entry that fits; when the chunk is split, the entries above it are
// shifted up by one and the tail is written; the granted entry is then
// written and the response posted; a miss scans the whole table. A free
// scans for the offset and then streams the whole table once through the
// merge logic before the response is posted; an unknown offset scans the
// whole table, and a null free is answered without a scan. Every scan goes
// through the single read port of the table RAM, one entry per cycle.
module first_fit_pool_allocator_top #(
    parameter int POOL_BYTES   = 1048576,
    parameter int MAX_CHUNKS   = 64,
    parameter int HEADER_BYTES = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ffpa_req_if.sink   i_req,
    ffpa_rsp_if.source o_rsp
);
    import ffpa_pkg::*;

    localparam int IDX_W = $clog2(MAX_CHUNKS);
    localparam int CNT_W = $clog2(MAX_CHUNKS + 1);

    localparam logic [OFFS_W:0]   HDR    = (OFFS_W+1)'(HEADER_BYTES);
    localparam logic [OFFS_W+1:0] SPLITM = (OFFS_W+2)'(HEADER_BYTES + SPLIT_SLACK);
    localparam logic [OFFS_W:0]   ALIGNM = (OFFS_W+1)'(ALIGN_MASK);
    localparam t_offset           INIT_SIZE = OFFS_W'(POOL_BYTES - HEADER_BYTES);

    // State codes
    localparam logic [3:0] ST_INIT  = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_AFIND = 4'd2;
    localparam logic [3:0] ST_SHIFT = 4'd3;
    localparam logic [3:0] ST_WNEW  = 4'd4;
    localparam logic [3:0] ST_WHIT  = 4'd5;
    localparam logic [3:0] ST_FFIND = 4'd6;
    localparam logic [3:0] ST_MERGE = 4'd7;
    localparam logic [3:0] ST_RESP  = 4'd8;

    // Registers and next values
    logic [3:0]       r_state,   n_state;
    logic [CNT_W-1:0] r_count,   n_count;
    logic [CNT_W-1:0] r_rd_idx,  n_rd_idx;
    logic             r_ev_vld,  n_ev_vld;
    logic [IDX_W-1:0] r_ev_idx,  n_ev_idx;
    t_chunk           r_hit,     n_hit;
    logic [IDX_W-1:0] r_hit_idx, n_hit_idx;
    logic             r_split,   n_split;
    logic [OFFS_W:0]  r_sz,      n_sz;
    t_offset          r_off,     n_off;
    t_offset          r_res_off, n_res_off;
    t_status          r_res_st,  n_res_st;
    t_chunk           r_cur,     n_cur;
    logic             r_cur_v,   n_cur_v;
    logic [CNT_W-1:0] r_wp,      n_wp;
    logic             r_out_vld, n_out_vld;
    t_offset          r_out_off, n_out_off;
    t_status          r_out_st,  n_out_st;

    // RAM port signals
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    t_chunk           ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [$bits(t_chunk)-1:0] ram_rdata;

    // Datapath helpers
    t_chunk            rd;
    t_chunk            rd_mrg;
    logic [OFFS_W:0]   req_nz;
    logic [OFFS_W:0]   sz_calc;
    logic              fit;
    logic              can_split;
    logic              off_match;
    logic [OFFS_W:0]   cur_end;
    logic              mergeable;
    logic [OFFS_W:0]   merged_size;
    logic [CNT_W-1:0]  hit_ext;

    ffpa_ram #(
        .WIDTH ($bits(t_chunk)),
        .DEPTH (MAX_CHUNKS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata)
    );

    // Handshake ports
    assign i_req.ready          = (r_state == ST_IDLE);
    assign o_rsp.valid          = r_out_vld;
    assign o_rsp.payload_offset = r_out_off;
    assign o_rsp.status         = r_out_st;

    // Entry under evaluation and the compares on it
    always_comb begin
        rd      = t_chunk'(ram_rdata);
        rd_mrg  = rd;
        if (r_ev_idx == r_hit_idx) begin
            rd_mrg.free = 1'b1;
        end
        req_nz  = (i_req.req_size == '0) ? (OFFS_W+1)'(1) : {1'b0, i_req.req_size};
        sz_calc = (req_nz + ALIGNM) & ~ALIGNM;
        fit       = rd.free && ({1'b0, rd.size} >= r_sz);
        can_split = ({2'b00, rd.size} >= ({1'b0, r_sz} + SPLITM))
                    && (r_count < CNT_W'(MAX_CHUNKS));
        off_match = (({1'b0, rd.start} + HDR) == {1'b0, r_off});
        cur_end   = {1'b0, r_cur.start} + HDR + {1'b0, r_cur.size};
        mergeable = r_cur.free && rd_mrg.free && (cur_end == {1'b0, rd_mrg.start});
        merged_size = {1'b0, r_cur.size} + HDR + {1'b0, rd_mrg.size};
        hit_ext   = CNT_W'(r_hit_idx);
    end

    // Sequencer: scan, shift and merge passes over the table
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_rd_idx  = r_rd_idx;
        n_ev_vld  = r_ev_vld;
        n_ev_idx  = r_ev_idx;
        n_hit     = r_hit;
        n_hit_idx = r_hit_idx;
        n_split   = r_split;
        n_sz      = r_sz;
        n_off     = r_off;
        n_res_off = r_res_off;
        n_res_st  = r_res_st;
        n_cur     = r_cur;
        n_cur_v   = r_cur_v;
        n_wp      = r_wp;
        n_out_vld = r_out_vld;
        n_out_off = r_out_off;
        n_out_st  = r_out_st;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;

        // Output register drains on a taken transaction
        if (r_out_vld && o_rsp.ready) begin
            n_out_vld = 1'b0;
        end

        // Forward scan: one read per cycle while entries remain
        if (r_state == ST_AFIND || r_state == ST_FFIND || r_state == ST_MERGE) begin
            if (r_rd_idx < r_count) begin
                ram_re   = 1'b1;
                ram_raddr = r_rd_idx[IDX_W-1:0];
                n_rd_idx = r_rd_idx + CNT_W'(1);
                n_ev_vld = 1'b1;
                n_ev_idx = r_rd_idx[IDX_W-1:0];
            end else begin
                n_ev_vld = 1'b0;
            end
        end

        case (r_state)
            ST_INIT: begin
                // Whole pool as one free chunk
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = '{start: '0, size: INIT_SIZE, free: 1'b1};
                n_state   = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_rd_idx = '0;
                    n_ev_vld = 1'b0;
                    n_off    = i_req.free_offset;
                    if (i_req.req_type == REQ_ALLOC) begin
                        n_sz    = sz_calc;
                        n_state = ST_AFIND;
                    end else if (i_req.free_offset == '0) begin
                        n_res_off = '0;
                        n_res_st  = STAT_OK;
                        n_state   = ST_RESP;
                    end else begin
                        n_state = ST_FFIND;
                    end
                end
            end
            ST_AFIND: begin
                if (r_ev_vld && fit) begin
                    n_hit     = rd;
                    n_hit_idx = r_ev_idx;
                    n_split   = can_split;
                    n_res_off = OFFS_W'({1'b0, rd.start} + HDR);
                    n_res_st  = STAT_OK;
                    n_rd_idx  = r_count - CNT_W'(1);
                    n_ev_vld  = 1'b0;
                    n_state   = can_split ? ST_SHIFT : ST_WHIT;
                end else if (!r_ev_vld && r_rd_idx >= r_count) begin
                    n_res_off = '0;
                    n_res_st  = STAT_NOFIT;
                    n_state   = ST_RESP;
                end
            end
            ST_SHIFT: begin
                // Move entries above the hit up by one, top first
                if (r_rd_idx > hit_ext) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_rd_idx[IDX_W-1:0];
                    n_rd_idx  = r_rd_idx - CNT_W'(1);
                    n_ev_vld  = 1'b1;
                    n_ev_idx  = r_rd_idx[IDX_W-1:0];
                end else begin
                    n_ev_vld = 1'b0;
                end
                if (r_ev_vld) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_ev_idx + IDX_W'(1);
                    ram_wdata = rd;
                end
                if (!r_ev_vld && r_rd_idx <= hit_ext) begin
                    n_state = ST_WNEW;
                end
            end
            ST_WNEW: begin
                // Split tail becomes a free chunk right after the hit
                ram_we          = 1'b1;
                ram_waddr       = r_hit_idx + IDX_W'(1);
                ram_wdata.start = OFFS_W'({1'b0, r_hit.start} + HDR + r_sz);
                ram_wdata.size  = OFFS_W'({1'b0, r_hit.size} - r_sz - HDR);
                ram_wdata.free  = 1'b1;
                n_state         = ST_WHIT;
            end
            ST_WHIT: begin
                ram_we          = 1'b1;
                ram_waddr       = r_hit_idx;
                ram_wdata.start = r_hit.start;
                ram_wdata.size  = r_split ? r_sz[OFFS_W-1:0] : r_hit.size;
                ram_wdata.free  = 1'b0;
                if (r_split) begin
                    n_count = r_count + CNT_W'(1);
                end
                n_state = ST_RESP;
            end
            ST_FFIND: begin
                if (r_ev_vld && off_match) begin
                    n_hit_idx = r_ev_idx;
                    n_rd_idx  = '0;
                    n_ev_vld  = 1'b0;
                    n_cur_v   = 1'b0;
                    n_wp      = '0;
                    n_state   = ST_MERGE;
                end else if (!r_ev_vld && r_rd_idx >= r_count) begin
                    n_res_off = '0;
                    n_res_st  = STAT_BADFREE;
                    n_state   = ST_RESP;
                end
            end
            ST_MERGE: begin
                // Streaming coalesce: write pointer trails the read pointer
                if (r_ev_vld) begin
                    if (!r_cur_v) begin
                        n_cur   = rd_mrg;
                        n_cur_v = 1'b1;
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = r_wp[IDX_W-1:0];
                        ram_wdata = r_cur;
                        n_wp      = r_wp + CNT_W'(1);
                        if (mergeable) begin
                            ram_wdata.size = merged_size[OFFS_W-1:0];
                            n_cur_v        = 1'b0;
                        end else begin
                            n_cur = rd_mrg;
                        end
                    end
                end else if (r_rd_idx >= r_count) begin
                    if (r_cur_v) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_wp[IDX_W-1:0];
                        ram_wdata = r_cur;
                    end
                    n_count   = r_wp + CNT_W'(r_cur_v);
                    n_cur_v   = 1'b0;
                    n_res_off = '0;
                    n_res_st  = STAT_OK;
                    n_state   = ST_RESP;
                end
            end
            ST_RESP: begin
                if (!r_out_vld || o_rsp.ready) begin
                    n_out_vld = 1'b1;
                    n_out_off = r_res_off;
                    n_out_st  = r_res_st;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_INIT;
            r_count   <= CNT_W'(1);
            r_ev_vld  <= 1'b0;
            r_cur_v   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_ev_vld  <= n_ev_vld;
            r_cur_v   <= n_cur_v;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rd_idx  <= n_rd_idx;
        r_ev_idx  <= n_ev_idx;
        r_hit     <= n_hit;
        r_hit_idx <= n_hit_idx;
        r_split   <= n_split;
        r_sz      <= n_sz;
        r_off     <= n_off;
        r_res_off <= n_res_off;
        r_res_st  <= n_res_st;
        r_cur     <= n_cur;
        r_wp      <= n_wp;
        r_out_off <= n_out_off;
        r_out_st  <= n_out_st;
    end

    // Chunk count stays within the table
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) && (r_count <= CNT_W'(MAX_CHUNKS)))
        else $error("chunk count out of range");

    // Table writes land at most one entry past the end of the live table
    a_wr_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (CNT_W'(ram_waddr) <= r_count))
        else $error("table write beyond chunk count");

    // Failed requests carry no offset
    a_fail_no_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status != STAT_OK)) |-> (o_rsp.payload_offset == '0))
        else $error("offset on failed response");

    // The table size only changes while a request is in progress
    a_idle_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |=> $stable(r_count))
        else $error("chunk count changed while idle");

    // A pending response waits for the output register to drain
    a_resp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_RESP) && r_out_vld && !o_rsp.ready) |=> (r_state == ST_RESP))
        else $error("response overwrote a pending transaction");

endmodule

### src/ffpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ffpa_ram #(
    parameter int WIDTH = 41,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

### tb/tb.sv
// Self-checking testbench of the first-fit pool allocator: directed and random requests.
`timescale 1ns / 1ps

module tb;
    import ffpa_pkg::*;

    localparam int POOL_BYTES   = 1048576;
    localparam int MAX_CHUNKS   = 64;
    localparam int HEADER_BYTES = 32;

    localparam int RANDOM_ITEMS = 1030;
    localparam int PHASE_ITEMS  = 160;
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 600;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 2 * MAX_CHUNKS + 40;
    localparam int MAX_SHOWN    = 10;
    localparam int OFFS_MAX     = (1 << OFFS_W) - 1;

    typedef struct packed {
        logic    kind;
        t_offset req_size;
        t_offset free_offset;
    } t_pool_req;

    typedef struct packed {
        t_offset payload_offset;
        t_status status;
    } t_pool_rsp;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // TB-side drive registers, all known from time zero
    logic      req_valid = 1'b0;
    t_pool_req req_item  = '0;
    logic      rsp_ready = 1'b0;
    logic      rsp_hold  = 1'b0;

    ffpa_req_if req_ch ();
    ffpa_rsp_if rsp_ch ();

    assign req_ch.valid       = req_valid;
    assign req_ch.req_type    = req_item.kind;
    assign req_ch.req_size    = req_item.req_size;
    assign req_ch.free_offset = req_item.free_offset;
    assign rsp_ch.ready       = rsp_ready;

    first_fit_pool_allocator_top #(
        .POOL_BYTES  (POOL_BYTES),
        .MAX_CHUNKS  (MAX_CHUNKS),
        .HEADER_BYTES(HEADER_BYTES)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    // Clock and reset
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Chunk table shadow
    int chunk_base [MAX_CHUNKS];
    int chunk_room [MAX_CHUNKS];
    bit chunk_open [MAX_CHUNKS];
    int n_chunks;

    t_pool_req req_backlog [$];
    t_pool_rsp due_rsps [$];
    int        n_queued = 0;
    int        n_taken  = 0;
    int        errors   = 0;

    // Whole pool as one free chunk
    function automatic void pool_reset();
        for (int k = 0; k < MAX_CHUNKS; k++) begin
            chunk_base[k] = 0;
            chunk_room[k] = 0;
            chunk_open[k] = 1'b0;
        end
        chunk_room[0] = POOL_BYTES - HEADER_BYTES;
        chunk_open[0] = 1'b1;
        n_chunks      = 1;
    endfunction

    // Apply one request to the shadow table and return the response it owes
    function automatic t_pool_rsp pool_step(t_pool_req q);
        t_pool_rsp r;
        int        sz;
        int        hit;
        r.payload_offset = '0;
        r.status         = STAT_OK;
        if (q.kind == REQ_ALLOC) begin
            r.status = STAT_NOFIT;
            sz = (q.req_size == 0) ? 1 : int'(q.req_size);
            sz = (sz + ALIGN_MASK) & ~ALIGN_MASK;
            for (int i = 0; i < n_chunks; i++) begin
                if (chunk_open[i] && chunk_room[i] >= sz) begin
                    // split off the tail as a new free chunk when it is worth it
                    if (chunk_room[i] >= sz + HEADER_BYTES + SPLIT_SLACK &&
                        n_chunks < MAX_CHUNKS) begin
                        for (int j = n_chunks; j > i + 1; j--) begin
                            chunk_base[j] = chunk_base[j - 1];
                            chunk_room[j] = chunk_room[j - 1];
                            chunk_open[j] = chunk_open[j - 1];
                        end
                        chunk_base[i + 1] = chunk_base[i] + HEADER_BYTES + sz;
                        chunk_room[i + 1] = chunk_room[i] - sz - HEADER_BYTES;
                        chunk_open[i + 1] = 1'b1;
                        n_chunks++;
                        chunk_room[i] = sz;
                    end
                    chunk_open[i]    = 1'b0;
                    r.payload_offset = t_offset'(chunk_base[i] + HEADER_BYTES);
                    r.status         = STAT_OK;
                    return r;
                end
            end
            return r;
        end
        // free: null is a no-op
        if (q.free_offset == 0)
            return r;
        hit = -1;
        for (int i = 0; i < n_chunks; i++) begin
            if (chunk_base[i] + HEADER_BYTES == int'(q.free_offset)) begin
                hit = i;
                break;
            end
        end
        if (hit < 0) begin
            r.status = STAT_BADFREE;
            return r;
        end
        chunk_open[hit] = 1'b1;
        // single coalescing pass; steps past each absorbed neighbor
        for (int p = 0; p + 1 < n_chunks; p++) begin
            if (chunk_open[p] && chunk_open[p + 1] &&
                chunk_base[p] + HEADER_BYTES + chunk_room[p] == chunk_base[p + 1]) begin
                chunk_room[p] += HEADER_BYTES + chunk_room[p + 1];
                for (int j = p + 1; j + 1 < n_chunks; j++) begin
                    chunk_base[j] = chunk_base[j + 1];
                    chunk_room[j] = chunk_room[j + 1];
                    chunk_open[j] = chunk_open[j + 1];
                end
                n_chunks--;
            end
        end
        return r;
    endfunction

    // Gap length: mostly short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 90);
    endfunction

    task automatic log_miss(string what, logic [31:0] exp_v, logic [31:0] got_v);
        errors++;
        if (errors <= MAX_SHOWN)
            $display("tb: %s mismatch: expected %0d, got %0d", what, exp_v, got_v);
    endtask

    // Request driver
    int req_gap    = 0;
    bit req_steady = 1'b0;

    always @(posedge i_clk) begin : drive_blk
        logic      nxt_valid;
        t_pool_req nxt_item;
        if (!i_rst_n) begin
            req_valid <= 1'b0;
        end else begin
            nxt_valid = req_valid;
            nxt_item  = req_item;
            if (req_valid && req_ch.ready) begin
                due_rsps.push_back(pool_step(req_item));
                n_taken++;
                nxt_valid = 1'b0;
                if ($urandom_range(0, 39) == 0)
                    req_steady = !req_steady;
                req_gap = req_steady ? 0 : idle_len();
            end
            if (!nxt_valid) begin
                if (req_gap > 0) begin
                    req_gap--;
                end else if (req_backlog.size() > 0) begin
                    nxt_item  = req_backlog.pop_front();
                    nxt_valid = 1'b1;
                end
            end
            req_valid <= nxt_valid;
            req_item  <= nxt_item;
        end
    end

    // Response monitor and checker
    int rsp_gap    = 0;
    bit rsp_steady = 1'b0;

    always @(posedge i_clk) begin : watch_blk
        t_pool_rsp want;
        if (!i_rst_n) begin
            rsp_ready <= 1'b0;
        end else begin
            if (rsp_ready && rsp_ch.valid) begin
                if (due_rsps.size() == 0) begin
                    log_miss("unexpected response, offset", 32'd0, rsp_ch.payload_offset);
                end else begin
                    want = due_rsps.pop_front();
                    if (rsp_ch.payload_offset !== want.payload_offset)
                        log_miss("payload_offset", want.payload_offset,
                                 rsp_ch.payload_offset);
                    if (rsp_ch.status !== want.status)
                        log_miss("status", want.status, rsp_ch.status);
                end
                if ($urandom_range(0, 39) == 0)
                    rsp_steady = !rsp_steady;
                rsp_gap = rsp_steady ? 0 : idle_len();
            end else if (!rsp_ready && rsp_gap > 0) begin
                rsp_gap--;
            end
            rsp_ready <= (rsp_gap == 0) && !rsp_hold;
        end
    end

    // Long receiver stall so the block backs up into its request side
    initial begin
        wait (n_taken >= HOLD_AFTER);
        @(posedge i_clk);
        rsp_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rsp_hold <= 1'b0;
    end

    // Watchdog on cycles with no transaction on either side
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((req_valid && req_ch.ready) || (rsp_ready && rsp_ch.valid)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_req(logic kind, int sz, int off);
        t_pool_req q;
        while (req_backlog.size() >= 2)
            @(negedge i_clk);
        q.kind        = kind;
        q.req_size    = t_offset'(sz);
        q.free_offset = t_offset'(off);
        req_backlog.push_back(q);
        n_queued++;
    endtask

    // Wait until every queued request has been taken and predicted
    task automatic settle();
        while (n_taken != n_queued)
            @(negedge i_clk);
    endtask

    // Stimulus
    initial begin : stim_blk
        int r;
        int sz;
        int off;
        int big_off;
        int tail_off;
        bit filling;
        int held_offs [$];
        int spare_offs [$];

        pool_reset();
        wait (i_rst_n);

        // rounding of tiny sizes and a request no chunk can hold
        push_req(REQ_ALLOC, 0, $urandom_range(0, OFFS_MAX));
        push_req(REQ_ALLOC, 1, $urandom_range(0, OFFS_MAX));
        push_req(REQ_ALLOC, 16, $urandom_range(0, OFFS_MAX));
        push_req(REQ_ALLOC, 17, $urandom_range(0, OFFS_MAX));
        push_req(REQ_ALLOC, OFFS_MAX, OFFS_MAX);
        // null free, unknown offsets
        push_req(REQ_FREE, OFFS_MAX, 0);
        push_req(REQ_FREE, $urandom_range(0, OFFS_MAX), 5);
        push_req(REQ_FREE, $urandom_range(0, OFFS_MAX), 33);
        // frees with allocated neighbors, then a double free
        push_req(REQ_FREE, $urandom_range(0, OFFS_MAX), 128);
        push_req(REQ_FREE, $urandom_range(0, OFFS_MAX), 32);
        push_req(REQ_FREE, $urandom_range(0, OFFS_MAX), 32);
        // three free in a row: the pass skips past the absorbed one
        push_req(REQ_FREE, $urandom_range(0, OFFS_MAX), 80);
        push_req(REQ_FREE, $urandom_range(0, OFFS_MAX), 176);
        // exact fit, then a split of the big chunk
        push_req(REQ_ALLOC, 112, $urandom_range(0, OFFS_MAX));
        push_req(REQ_ALLOC, 96, $urandom_range(0, OFFS_MAX));

        // smallest split possible leaves a 16-byte tail
        settle();
        push_req(REQ_ALLOC, chunk_room[n_chunks - 1] - 48, $urandom_range(0, OFFS_MAX));
        push_req(REQ_ALLOC, 0, $urandom_range(0, OFFS_MAX));
        push_req(REQ_ALLOC, 16, $urandom_range(0, OFFS_MAX));
        settle();
        big_off  = chunk_base[n_chunks - 2] + HEADER_BYTES;
        tail_off = chunk_base[n_chunks - 1] + HEADER_BYTES;
        push_req(REQ_FREE, $urandom_range(0, OFFS_MAX), big_off);
        // just under the split margin: whole chunk granted
        settle();
        push_req(REQ_ALLOC, chunk_room[n_chunks - 2] - HEADER_BYTES,
                 $urandom_range(0, OFFS_MAX));
        push_req(REQ_FREE, $urandom_range(0, OFFS_MAX), big_off);
        push_req(REQ_FREE, $urandom_range(0, OFFS_MAX), tail_off);
        push_req(REQ_FREE, $urandom_range(0, OFFS_MAX), 32);
        push_req(REQ_FREE, $urandom_range(0, OFFS_MAX), 176);

        // Random part: alternating fill and drain phases
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            filling = ((k / PHASE_ITEMS) % 2) == 0;
            if ($urandom_range(0, 99) < (filling ? 85 : 30)) begin
                r = $urandom_range(0, 99);
                if (r < 60)
                    sz = $urandom_range(0, 64);
                else if (r < 85)
                    sz = $urandom_range(65, 4096);
                else if (r < 97)
                    sz = $urandom_range(4097, 65536);
                else
                    sz = $urandom_range(0, OFFS_MAX);
                push_req(REQ_ALLOC, sz, $urandom_range(0, OFFS_MAX));
            end else begin
                held_offs.delete();
                spare_offs.delete();
                for (int i = 0; i < n_chunks; i++) begin
                    if (chunk_open[i])
                        spare_offs.push_back(chunk_base[i] + HEADER_BYTES);
                    else
                        held_offs.push_back(chunk_base[i] + HEADER_BYTES);
                end
                r   = $urandom_range(0, 99);
                off = $urandom_range(0, OFFS_MAX);
                if (r < 70) begin
                    if (held_offs.size() > 0)
                        off = held_offs[$urandom_range(0, held_offs.size() - 1)];
                end else if (r < 80) begin
                    if (spare_offs.size() > 0)
                        off = spare_offs[$urandom_range(0, spare_offs.size() - 1)];
                end else if (r < 87) begin
                    off = 0;
                end else if (r >= 94 && held_offs.size() > 0) begin
                    // near miss of a live payload
                    off = held_offs[$urandom_range(0, held_offs.size() - 1)] +
                          ($urandom_range(0, 1) ? 16 : -16);
                end
                push_req(REQ_FREE, $urandom_range(0, OFFS_MAX), off);
            end
        end

        // Drain
        settle();
        while (due_rsps.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (errors == 0 && due_rsps.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
